@@ rtl/core/bipp_pkg.sv @@
`default_nettype none

package bipp_pkg;

  // Sample and position widths.
  localparam int unsigned PixW   = 8;
  localparam int unsigned PosW   = 9;
  localparam int unsigned PosMax = (1 << PosW) - 1;

  // Weighted diagonal division: the divisor x+y+2 reaches 2*PosMax+2.
  localparam int unsigned DvsW = PosW + 2;
  // Each product (pos+1)*sample needs PosW+1+PixW bits, and so does their sum,
  // because the sum never exceeds 2*(PosMax+1)*255.
  localparam int unsigned NumW = PosW + 1 + PixW;
  // The quotient is a weighted mean of two samples, so it fits a sample.
  localparam int unsigned QuoW = PixW;

  localparam logic [PixW-1:0] PixMaxVal = '1;

  typedef enum logic [3:0] {
    ModeNone       = 4'd0,
    ModeCorner     = 4'd1,
    ModeH          = 4'd2,
    ModeV          = 4'd3,
    ModeDc         = 4'd4,
    ModeDcMedian   = 4'd5,
    ModeMedian     = 4'd6,
    ModeAvg        = 4'd7,
    ModeTrueMotion = 4'd8,
    ModePaeth      = 4'd9,
    ModeLdiag      = 4'd10,
    ModeHv         = 4'd11,
    ModeJpegLs     = 4'd12,
    ModeDiff       = 4'd13
  } bipp_mode_e;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [DvsW-1:0] dvs;
    logic [QuoW-1:0] quo;
    logic [PixW-1:0] alt;
    logic            use_div;
  } bipp_cell_data_t;

endpackage

`default_nettype wire

@@ rtl/core/bipp_cell.sv @@
`default_nettype none

module bipp_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  output logic                       ready_o,
  input  bipp_pkg::bipp_cell_data_t  data_i,
  output logic                       valid_o,
  input  wire                        ready_i,
  output bipp_pkg::bipp_cell_data_t  data_o
);

  logic                              valid_q;
  bipp_pkg::bipp_cell_data_t         data_q;
  bipp_pkg::bipp_cell_data_t         data_d;
  logic [bipp_pkg::NumW-1:0]         dvs_shift;
  logic [bipp_pkg::NumW:0]           trial;

  assign ready_o = !valid_q || ready_i;

  // One restoring step: try to take divisor * 2^BitIdx out of the remainder.
  always_comb begin
    dvs_shift = bipp_pkg::NumW'(data_i.dvs) << BitIdx;
    trial     = {1'b0, data_i.rem} - {1'b0, dvs_shift};
    data_d    = data_i;
    if (!trial[bipp_pkg::NumW]) begin
      data_d.rem         = trial[bipp_pkg::NumW-1:0];
      data_d.quo[BitIdx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/core/bipp_front.sv @@
`default_nettype none

module bipp_front #(
  parameter int unsigned MaxBlock = 512
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  bipp_pkg::bipp_mode_e             mode_i,
  input  wire                              valid_i,
  output logic                             ready_o,
  input  wire  [bipp_pkg::PosW-1:0]        pos_x_i,
  input  wire  [bipp_pkg::PosW-1:0]        pos_y_i,
  input  wire  [bipp_pkg::PixW-1:0]        above_i,
  input  wire  [bipp_pkg::PixW-1:0]        beside_i,
  input  wire  [bipp_pkg::PixW-1:0]        corner_sample_i,
  input  wire  [bipp_pkg::PixW-1:0]        block_mean_i,
  input  wire  [bipp_pkg::PixW-1:0]        above_left_i,
  input  wire  [bipp_pkg::PixW-1:0]        above_two_i,
  input  wire  [bipp_pkg::PixW-1:0]        beside_two_i,
  input  wire  [bipp_pkg::PixW-1:0]        diag_above_i,
  input  wire  [bipp_pkg::PixW-1:0]        diag_beside_i,
  output logic                             valid_o,
  input  wire                              ready_i,
  output bipp_pkg::bipp_cell_data_t        data_o
);

  localparam int unsigned PosLimInt =
      (MaxBlock - 1 > bipp_pkg::PosMax) ? bipp_pkg::PosMax : MaxBlock - 1;
  localparam logic [bipp_pkg::PosW-1:0] PosLim = bipp_pkg::PosW'(PosLimInt);
  localparam int unsigned ProdW = bipp_pkg::NumW;

  function automatic logic [bipp_pkg::PixW-1:0] min8(input logic [7:0] a,
                                                     input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [bipp_pkg::PixW-1:0] max8(input logic [7:0] a,
                                                     input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [bipp_pkg::PixW-1:0] med3(input logic [7:0] a,
                                                     input logic [7:0] b,
                                                     input logic [7:0] c);
    return max8(min8(a, b), min8(max8(a, b), c));
  endfunction

  function automatic logic [bipp_pkg::PixW-1:0] clamp12(input logic signed [11:0] v);
    logic [bipp_pkg::PixW-1:0] r;
    if (v < 12'sd0) begin
      r = '0;
    end else if (v > 12'sd255) begin
      r = bipp_pkg::PixMaxVal;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [9:0] mag11(input logic signed [10:0] v);
    return v[10] ? 10'(-v) : v[9:0];
  endfunction

  // Stage one registers.
  logic                       s1_valid_q;
  logic [ProdW-1:0]           s1_pa_q;
  logic [ProdW-1:0]           s1_pb_q;
  logic [bipp_pkg::DvsW-1:0]  s1_dvs_q;
  logic [bipp_pkg::PixW-1:0]  s1_alt_q;
  logic                       s1_div_q;
  logic                       s1_ready;

  // Stage two registers.
  logic                       s2_valid_q;
  bipp_pkg::bipp_cell_data_t  s2_data_q;
  bipp_pkg::bipp_cell_data_t  s2_data_d;

  logic [bipp_pkg::PosW-1:0]  x_sat;
  logic [bipp_pkg::PosW-1:0]  y_sat;
  logic [bipp_pkg::PosW:0]    x_inc;
  logic [bipp_pkg::PosW:0]    y_inc;
  logic [ProdW-1:0]           pa;
  logic [ProdW-1:0]           pb;
  logic [bipp_pkg::DvsW-1:0]  dvs;
  logic [bipp_pkg::PixW-1:0]  alt;
  logic                       use_div;

  logic [bipp_pkg::PixW-1:0]  avg;
  logic signed [11:0]         tm_s;
  logic signed [11:0]         diff_s;
  logic signed [11:0]         half_s;
  logic [9:0]                 d_l;
  logic [9:0]                 d_t;
  logic [9:0]                 d_c;
  logic [bipp_pkg::PixW-1:0]  paeth;
  logic [bipp_pkg::PixW-1:0]  lo;
  logic [bipp_pkg::PixW-1:0]  hi;
  logic [9:0]                 grad;
  logic [bipp_pkg::PixW-1:0]  jls;

  always_comb begin
    x_sat = (pos_x_i > PosLim) ? PosLim : pos_x_i;
    y_sat = (pos_y_i > PosLim) ? PosLim : pos_y_i;
    x_inc = {1'b0, x_sat} + 1'b1;
    y_inc = {1'b0, y_sat} + 1'b1;
    pa    = ProdW'(x_inc) * ProdW'(diag_above_i);
    pb    = ProdW'(y_inc) * ProdW'(diag_beside_i);
    dvs   = bipp_pkg::DvsW'(x_sat) + bipp_pkg::DvsW'(y_sat) + bipp_pkg::DvsW'(2);
  end

  // Predictors other than the weighted diagonal.
  always_comb begin
    avg    = 8'((9'(above_i) + 9'(beside_i)) >> 1);
    tm_s   = $signed({4'b0, above_i}) + $signed({4'b0, beside_i})
           - $signed({4'b0, corner_sample_i});
    diff_s = $signed({3'b0, beside_two_i, 1'b0}) - $signed({4'b0, beside_i})
           + $signed({3'b0, above_two_i, 1'b0}) - $signed({4'b0, above_i});
    half_s = diff_s >>> 1;

    // Paeth distances with the estimate folded in: |p-L| = |T-C|,
    // |p-T| = |L-C|, |p-C| = |T+L-2C|.
    d_l = mag11($signed({3'b0, above_i}) - $signed({3'b0, corner_sample_i}));
    d_t = mag11($signed({3'b0, beside_i}) - $signed({3'b0, corner_sample_i}));
    d_c = mag11($signed({3'b0, above_i}) + $signed({3'b0, beside_i})
              - $signed({2'b0, corner_sample_i, 1'b0}));
    if (d_l <= d_t && d_l <= d_c) begin
      paeth = beside_i;
    end else if (d_t <= d_c) begin
      paeth = above_i;
    end else begin
      paeth = corner_sample_i;
    end

    lo   = min8(above_i, beside_i);
    hi   = max8(above_i, beside_i);
    grad = 10'(above_i) + 10'(beside_i) - 10'(above_left_i);
    if (above_left_i >= hi) begin
      jls = lo;
    end else if (above_left_i <= lo) begin
      jls = hi;
    end else begin
      jls = grad[7:0];
    end

    use_div = 1'b0;
    unique case (mode_i)
      bipp_pkg::ModeNone:       alt = '0;
      bipp_pkg::ModeCorner:     alt = corner_sample_i;
      bipp_pkg::ModeH:          alt = beside_i;
      bipp_pkg::ModeV:          alt = above_i;
      bipp_pkg::ModeDc:         alt = block_mean_i;
      bipp_pkg::ModeDcMedian:   alt = med3(block_mean_i, above_i, beside_i);
      bipp_pkg::ModeMedian:     alt = med3(corner_sample_i, above_i, beside_i);
      bipp_pkg::ModeAvg:        alt = avg;
      bipp_pkg::ModeTrueMotion: alt = clamp12(tm_s);
      bipp_pkg::ModePaeth:      alt = paeth;
      bipp_pkg::ModeLdiag: begin
        alt     = '0;
        use_div = 1'b1;
      end
      bipp_pkg::ModeHv: begin
        if (x_sat > y_sat) begin
          alt = above_i;
        end else if (y_sat > x_sat) begin
          alt = beside_i;
        end else begin
          alt = avg;
        end
      end
      bipp_pkg::ModeJpegLs:     alt = jls;
      bipp_pkg::ModeDiff:       alt = clamp12(half_s);
      default:                  alt = '0;
    endcase
  end

  assign s1_ready = !s2_valid_q || ready_i;
  assign ready_o  = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready_o) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      s1_pa_q  <= pa;
      s1_pb_q  <= pb;
      s1_dvs_q <= dvs;
      s1_alt_q <= alt;
      s1_div_q <= use_div;
    end
  end

  // The sum of the two products never exceeds NumW bits, so the carry is dropped.
  always_comb begin
    s2_data_d.rem     = bipp_pkg::NumW'({1'b0, s1_pa_q} + {1'b0, s1_pb_q});
    s2_data_d.dvs     = s1_dvs_q;
    s2_data_d.quo     = '0;
    s2_data_d.alt     = s1_alt_q;
    s2_data_d.use_div = s1_div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s1_valid_q) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_data_q;

endmodule

`default_nettype wire

@@ rtl/core/block_intra_pixel_predictor.sv @@
`default_nettype none

// Intra pixel predictor. Each input transaction carries one pixel position and
// its neighbor samples, and yields exactly one output transaction holding the
// 8-bit prediction chosen by the predict_mode register (APB offset 0). The
// block accepts one transaction per clock while the output side keeps up, and
// every mode takes the same path from input to output: two front stages
// (mode evaluation and the two diagonal products, then their sum), a chain of
// eight divider cells that each resolve one quotient bit of the left-diagonal
// weighted mean, and the output register. Every stage has its own valid bit,
// so gaps in the stream are squeezed out and new transactions keep entering
// while a finished result waits on the output. The mode register may only be
// written while no transaction is in flight.

module block_intra_pixel_predictor #(
  parameter int unsigned MaxBlock = 512
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,

  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [2:0]                 paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,

  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  [bipp_pkg::PosW-1:0]  pos_x_i,
  input  wire  [bipp_pkg::PosW-1:0]  pos_y_i,
  input  wire  [bipp_pkg::PixW-1:0]  above_i,
  input  wire  [bipp_pkg::PixW-1:0]  beside_i,
  input  wire  [bipp_pkg::PixW-1:0]  corner_sample_i,
  input  wire  [bipp_pkg::PixW-1:0]  block_mean_i,
  input  wire  [bipp_pkg::PixW-1:0]  above_left_i,
  input  wire  [bipp_pkg::PixW-1:0]  above_two_i,
  input  wire  [bipp_pkg::PixW-1:0]  beside_two_i,
  input  wire  [bipp_pkg::PixW-1:0]  diag_above_i,
  input  wire  [bipp_pkg::PixW-1:0]  diag_beside_i,

  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [bipp_pkg::PixW-1:0]  prediction_o
);

  localparam int unsigned NumCells = bipp_pkg::QuoW;

  bipp_pkg::bipp_mode_e       mode_q;
  logic                       cfg_wr;

  logic                       chain_valid [0:NumCells];
  logic                       chain_ready [0:NumCells];
  bipp_pkg::bipp_cell_data_t  chain_data  [0:NumCells];

  logic                       out_valid_q;
  logic [bipp_pkg::PixW-1:0]  out_pred_q;

  // Configuration port. The only register sits at offset 0; bit 2 of the
  // address selects it, and the byte offset bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bipp_pkg::ModeNone;
    end else if (cfg_wr) begin
      mode_q <= bipp_pkg::bipp_mode_e'(pwdata[3:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata[3:0] = mode_q;
    end
  end

  // Front stages: all predictors except the weighted diagonal finish here; the
  // diagonal leaves with its numerator and divisor for the cell chain.
  bipp_front #(
    .MaxBlock (MaxBlock)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_q),
    .valid_i         (in_valid_i),
    .ready_o         (in_ready_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .above_i         (above_i),
    .beside_i        (beside_i),
    .corner_sample_i (corner_sample_i),
    .block_mean_i    (block_mean_i),
    .above_left_i    (above_left_i),
    .above_two_i     (above_two_i),
    .beside_two_i    (beside_two_i),
    .diag_above_i    (diag_above_i),
    .diag_beside_i   (diag_beside_i),
    .valid_o         (chain_valid[0]),
    .ready_i         (chain_ready[0]),
    .data_o          (chain_data[0])
  );

  // Divider chain. Cell i settles quotient bit QuoW-1-i, most significant
  // first, and passes the partial remainder on to its neighbor. The result of
  // the other modes rides along unchanged.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    bipp_cell #(
      .BitIdx (NumCells - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // Output register: picks the quotient or the pass-through prediction.
  assign chain_ready[NumCells] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[NumCells]) begin
      out_valid_q <= chain_valid[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[NumCells] && chain_valid[NumCells]) begin
      out_pred_q <= chain_data[NumCells].use_div ? chain_data[NumCells].quo
                                                 : chain_data[NumCells].alt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prediction_o = out_pred_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_block_intra_pixel_predictor.sv @@
`default_nettype none

// Testbench for the intra pixel predictor. Every input transaction yields
// exactly one prediction, so the bench keeps a queue of predicted pixel values
// that is filled when a transaction is accepted and drained as the block
// produces results. The mode register is written over the APB port only while
// the block is idle, and the bench keeps its own copy of the mode for the
// predictor.
module tb_block_intra_pixel_predictor;

  localparam int unsigned PosW = bipp_pkg::PosW;
  localparam int unsigned PixW = bipp_pkg::PixW;

  localparam int MaxBlockSize = 512;
  localparam int PosLimit     = MaxBlockSize - 1;
  // The extra wait after draining exceeds the block's input-to-output delay.
  localparam int PipeLatency  = 16;
  // A slow but correct run stays far below this.
  localparam int CycleLimit   = 200000;

  // APB byte addresses. Only the mode register exists. The spare address
  // belongs to a register index that the block must ignore.
  localparam logic [2:0] RegModeAddr  = 3'd0;
  localparam logic [2:0] RegSpareAddr = 3'd4;

  // Mode codes that the package leaves unused. They predict zero.
  localparam logic [3:0] ModeSpareLo = 4'd14;
  localparam logic [3:0] ModeSpareHi = 4'd15;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [PixW-1:0] above;
    logic [PixW-1:0] beside;
    logic [PixW-1:0] corner_sample;
    logic [PixW-1:0] block_mean;
    logic [PixW-1:0] above_left;
    logic [PixW-1:0] above_two;
    logic [PixW-1:0] beside_two;
    logic [PixW-1:0] diag_above;
    logic [PixW-1:0] diag_beside;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        pix_valid = 1'b0;
  logic        pix_ready;
  pixel_t      pix_drv = '0;

  logic             pred_valid;
  logic             pred_ready = 1'b0;
  logic [PixW-1:0]  pred_value;

  // Shared state of the bench.
  logic [PixW-1:0] predictions_due[$];
  logic [3:0]      cur_mode = bipp_pkg::ModeNone;
  int unsigned     mismatch_count = 0;
  int unsigned     result_count = 0;
  int unsigned     cycle_count = 0;
  bit              idle_on = 1'b0;
  int unsigned     hold_request = 0;

  always #2 clk = ~clk;

  block_intra_pixel_predictor #(
    .MaxBlock(MaxBlockSize)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (pix_valid),
    .in_ready_o     (pix_ready),
    .pos_x_i        (pix_drv.pos_x),
    .pos_y_i        (pix_drv.pos_y),
    .above_i        (pix_drv.above),
    .beside_i       (pix_drv.beside),
    .corner_sample_i(pix_drv.corner_sample),
    .block_mean_i   (pix_drv.block_mean),
    .above_left_i   (pix_drv.above_left),
    .above_two_i    (pix_drv.above_two),
    .beside_two_i   (pix_drv.beside_two),
    .diag_above_i   (pix_drv.diag_above),
    .diag_beside_i  (pix_drv.diag_beside),
    .out_valid_o    (pred_valid),
    .out_ready_i    (pred_ready),
    .prediction_o   (pred_value)
  );

  // ---------------------------------------------------------------------------
  // Prediction of the block's output.
  // ---------------------------------------------------------------------------

  function automatic int clip_pixel(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Median of three, written as max(min(a,b), min(max(a,b),c)).
  function automatic int median3(int a, int b, int c);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

  function automatic logic [PixW-1:0] predict_pixel(pixel_t p, logic [3:0] mode);
    int x, y, t, l, c, dcv, ul, t2, l2, da, db;
    int est, dl, dt, dcn, s, r, lo, hi;
    // Positions beyond the block bound saturate to the last row or column.
    x   = (p.pos_x > PosLimit) ? PosLimit : int'(p.pos_x);
    y   = (p.pos_y > PosLimit) ? PosLimit : int'(p.pos_y);
    t   = p.above;
    l   = p.beside;
    c   = p.corner_sample;
    dcv = p.block_mean;
    ul  = p.above_left;
    t2  = p.above_two;
    l2  = p.beside_two;
    da  = p.diag_above;
    db  = p.diag_beside;
    lo  = (t < l) ? t : l;
    hi  = (t > l) ? t : l;
    case (mode)
      bipp_pkg::ModeCorner:     r = c;
      bipp_pkg::ModeH:          r = l;
      bipp_pkg::ModeV:          r = t;
      bipp_pkg::ModeDc:         r = dcv;
      bipp_pkg::ModeDcMedian:   r = median3(dcv, t, l);
      bipp_pkg::ModeMedian:     r = median3(c, t, l);
      bipp_pkg::ModeAvg:        r = (t + l) >> 1;
      bipp_pkg::ModeTrueMotion: r = clip_pixel(t + l - c);
      bipp_pkg::ModePaeth: begin
        est = t + l - c;
        dl  = abs_int(est - l);
        dt  = abs_int(est - t);
        dcn = abs_int(est - c);
        if (dl <= dt && dl <= dcn) r = l;
        else if (dt <= dcn) r = t;
        else r = c;
      end
      bipp_pkg::ModeLdiag:      r = ((x + 1) * da + (y + 1) * db) / (x + y + 2);
      bipp_pkg::ModeHv: begin
        if (x > y) r = t;
        else if (y > x) r = l;
        else r = (t + l) >> 1;
      end
      bipp_pkg::ModeJpegLs: begin
        if (ul >= hi) r = lo;
        else if (ul <= lo) r = hi;
        else r = t + l - ul;
      end
      bipp_pkg::ModeDiff: begin
        // Floor halving of a possibly negative sum: bias it first.
        s = 2 * l2 - l + 2 * t2 - t;
        r = ((s + 1024) >> 1) - 512;
      end
      // Mode none and the two unused codes predict zero.
      default:                  r = 0;
    endcase
    return PixW'(clip_pixel(r));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic pixel_t make_pixel(int x, int y, int t, int l, int c, int dcv,
                                        int ul, int t2, int l2, int da, int db);
    pixel_t p;
    p.pos_x         = PosW'(x);
    p.pos_y         = PosW'(y);
    p.above         = PixW'(t);
    p.beside        = PixW'(l);
    p.corner_sample = PixW'(c);
    p.block_mean    = PixW'(dcv);
    p.above_left    = PixW'(ul);
    p.above_two     = PixW'(t2);
    p.beside_two    = PixW'(l2);
    p.diag_above    = PixW'(da);
    p.diag_beside   = PixW'(db);
    return p;
  endfunction

  // Samples lean toward the rails so that the clamped modes saturate often.
  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return PosLimit;
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, PosLimit);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return make_pixel(rand_pos(), rand_pos(), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), rand_sample());
  endfunction

  // All tasks below are entered at a rising edge and return at one.

  // One APB write: a setup cycle, then the access cycle that holds until
  // pready. The bench copy of the mode follows the block at the write edge.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == RegModeAddr) cur_mode = data[3:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering pixels and wait until every prediction has come out.
  task automatic drain_pipeline();
    pix_valid <= 1'b0;
    while (predictions_due.size() != 0) @(posedge clk);
    repeat (PipeLatency) @(posedge clk);
  endtask

  // Mode changes happen only with the pipeline empty. The upper data bits are
  // random, since only the low nibble belongs to the register.
  task automatic set_mode(logic [3:0] mode);
    logic [31:0] word;
    drain_pipeline();
    word = $urandom;
    word[3:0] = mode;
    apb_write(RegModeAddr, word);
  endtask

  // Offer one pixel and hold it until accepted. Valid is left high after the
  // accepting edge; the next call either keeps it high with new data or
  // drops it for an idle burst, so valid gets a single update per edge.
  task automatic send_pixel(pixel_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_drv   <= p;
    do @(posedge clk); while (!pix_ready);
    predictions_due = {predictions_due, predict_pixel(p, cur_mode)};
  endtask

  task automatic send_in_mode(logic [3:0] mode, pixel_t p);
    if (mode != cur_mode) set_mode(mode);
    send_pixel(p);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks every prediction and drives the ready with random
  // stall bursts. A long hold-off is requested through hold_request and then
  // counted down here, cycle by cycle.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    logic [PixW-1:0] want;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (pred_valid && pred_ready) begin
          if (predictions_due.size() == 0) begin
            report_mismatch("prediction with no transaction pending", pred_value, 0);
          end else begin
            want = predictions_due.pop_front();
            if (pred_value !== want) begin
              report_mismatch($sformatf("prediction %0d", result_count), pred_value, want);
            end
          end
          result_count++;
        end
        if (hold_request != 0) begin
          hold_left    = hold_request;
          hold_request = 0;
        end
        if (hold_left != 0) begin
          hold_left--;
          pred_ready <= 1'b0;
        end else if (stall_left != 0) begin
          stall_left--;
          pred_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 6) - 1;
          pred_ready <= 1'b0;
        end else begin
          pred_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Edge values of every mode, including the reset mode (none), both clamp
  // directions, the Paeth choices, the HV diagonal and the unused codes.
  task automatic test_directed();
    idle_on = 1'b1;
    // The first item runs in the mode left by reset, which predicts zero.
    send_in_mode(bipp_pkg::ModeNone,
                 make_pixel(511, 511, 255, 255, 255, 255, 255, 255, 255, 255, 255));
    send_in_mode(bipp_pkg::ModeCorner,
                 make_pixel(0, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeH,
                 make_pixel(0, 511, 0, 255, 0, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeV,
                 make_pixel(511, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeDc,
                 make_pixel(3, 9, 0, 0, 0, 255, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeDcMedian,
                 make_pixel(1, 1, 10, 90, 0, 200, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeMedian,
                 make_pixel(1, 2, 0, 128, 255, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeAvg,
                 make_pixel(4, 4, 255, 255, 0, 0, 0, 0, 0, 0, 0));
    // TrueMotion above the top rail, then below zero.
    send_in_mode(bipp_pkg::ModeTrueMotion,
                 make_pixel(0, 0, 255, 255, 0, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeTrueMotion,
                 make_pixel(0, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0));
    // Paeth: a three-way tie picks left, then cases that pick above and corner.
    send_in_mode(bipp_pkg::ModePaeth,
                 make_pixel(0, 0, 100, 100, 100, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModePaeth,
                 make_pixel(0, 0, 50, 20, 10, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModePaeth,
                 make_pixel(0, 0, 0, 255, 128, 0, 0, 0, 0, 0, 0));
    // Weighted diagonal at the smallest and largest divisors.
    send_in_mode(bipp_pkg::ModeLdiag,
                 make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 0));
    send_in_mode(bipp_pkg::ModeLdiag,
                 make_pixel(511, 511, 0, 0, 0, 0, 0, 0, 0, 255, 255));
    send_in_mode(bipp_pkg::ModeLdiag,
                 make_pixel(511, 0, 0, 0, 0, 0, 0, 0, 0, 1, 255));
    // HV above, below and on the diagonal.
    send_in_mode(bipp_pkg::ModeHv,
                 make_pixel(5, 2, 200, 30, 0, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeHv,
                 make_pixel(2, 5, 200, 30, 0, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeHv,
                 make_pixel(7, 7, 255, 0, 0, 0, 0, 0, 0, 0, 0));
    // JPEG-LS: edge above, edge below, and the planar case.
    send_in_mode(bipp_pkg::ModeJpegLs,
                 make_pixel(0, 0, 10, 200, 0, 0, 255, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeJpegLs,
                 make_pixel(0, 0, 10, 200, 0, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeJpegLs,
                 make_pixel(0, 0, 10, 200, 0, 0, 100, 0, 0, 0, 0));
    // Second-order difference clamped low and high.
    send_in_mode(bipp_pkg::ModeDiff,
                 make_pixel(0, 0, 255, 255, 0, 0, 0, 0, 0, 0, 0));
    send_in_mode(bipp_pkg::ModeDiff,
                 make_pixel(0, 0, 0, 0, 0, 0, 0, 255, 255, 0, 0));
    send_in_mode(ModeSpareLo,
                 make_pixel(9, 9, 255, 255, 255, 255, 255, 255, 255, 255, 255));
    send_in_mode(ModeSpareHi,
                 make_pixel(9, 9, 255, 255, 255, 255, 255, 255, 255, 255, 255));
  endtask

  // A write to an address with no register behind it must leave the mode alone.
  task automatic test_spare_register();
    logic [31:0] word;
    set_mode(bipp_pkg::ModePaeth);
    word = $urandom;
    word[3:0] = bipp_pkg::ModeDc;
    // The bus goes idle between the two writes.
    @(posedge clk);
    apb_write(RegSpareAddr, word);
    repeat (8) send_pixel(rand_pixel());
  endtask

  // Random pixels in every mode code, then two random mode picks.
  task automatic test_random_modes();
    idle_on = 1'b1;
    for (int code = bipp_pkg::ModeNone; code <= ModeSpareHi; code++) begin
      set_mode(4'(code));
      repeat (16) send_pixel(rand_pixel());
    end
    repeat (2) begin
      set_mode(4'($urandom_range(bipp_pkg::ModeNone, ModeSpareHi)));
      repeat (16) send_pixel(rand_pixel());
    end
  endtask

  // The result side stops for a long stretch while pixels keep coming, so the
  // pipeline fills and the input has to stall.
  task automatic test_backpressure();
    set_mode(bipp_pkg::ModeLdiag);
    idle_on = 1'b0;
    hold_request = 80;
    repeat (40) send_pixel(rand_pixel());
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (5) begin
      set_mode(4'($urandom_range(bipp_pkg::ModeNone, bipp_pkg::ModeDiff)));
      repeat (20) send_pixel(rand_pixel());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_spare_register();
    test_random_modes();
    test_backpressure();
    test_full_rate();
    drain_pipeline();
    repeat (PipeLatency) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
